[hw/rtl/trapezoid_signal_statistics_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoid signal statistics block
// Implication checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_SIGNAL_STATISTICS_ASSERT_SVH
`define TRAPEZOID_SIGNAL_STATISTICS_ASSERT_SVH

// same-cycle implication
`define TSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define TSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Types and constants shared by the trapezoid statistics modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int ACC_BITS    = 64;
    localparam int CNT_BITS    = 6;

    localparam logic [CNT_BITS-1:0] DIV_LAST  = 6'd63;
    localparam logic [CNT_BITS-1:0] ROOT_LAST = 6'd31;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_ZERO_DUR  = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    typedef struct packed {
        logic [TIME_BITS-1:0]          timestamp;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_req;

    typedef struct packed {
        t_status                       status;
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic signed [SAMPLE_BITS-1:0] maximum;
        logic signed [SAMPLE_BITS-1:0] mean_value;
        logic [SAMPLE_BITS-2:0]        amplitude;
        logic [SAMPLE_BITS-1:0]        rms_value;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_ACC,
        S_DIV_A_INIT,
        S_DIV_A,
        S_DIV_B_INIT,
        S_DIV_B,
        S_ROOT_INIT,
        S_ROOT,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic prep;
        logic mul;
        logic acc;
        logic div_init_mean;
        logic div_init_sq;
        logic div_step;
        logic root_init;
        logic root_step;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/tss_ctrl.sv]
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: per-sample update, then divide, divide and square root on last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_ctrl
    import tss_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last ? S_DIV_A_INIT : S_IDLE;
            end
            S_DIV_A_INIT: begin
                o_cmd.div_init_mean = 1'b1;
                n_count             = '0;
                n_state             = S_DIV_A;
            end
            S_DIV_A: begin
                o_cmd.div_step = 1'b1;
                n_count        = r_count + 1'b1;
                if (r_count == DIV_LAST) begin
                    n_state = S_DIV_B_INIT;
                end
            end
            S_DIV_B_INIT: begin
                o_cmd.div_init_sq = 1'b1;
                n_count           = '0;
                n_state           = S_DIV_B;
            end
            S_DIV_B: begin
                o_cmd.div_step = 1'b1;
                n_count        = r_count + 1'b1;
                if (r_count == DIV_LAST) begin
                    n_state = S_ROOT_INIT;
                end
            end
            S_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_count         = '0;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_count         = r_count + 1'b1;
                if (r_count == ROOT_LAST) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // hold until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[hw/rtl/tss_datapath.sv]
// ----------------------------------------------------------------------------
// tss_datapath
// Record state, trapezoid accumulators, serial divider, serial square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_datapath
    import tss_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_in_req i_in_req,
    input  wire logic    i_out_stall,
    output t_dp_sts      o_sts,
    output logic         o_out_valid,
    output t_out_req     o_out_req
);

    // captured request
    logic [TIME_BITS-1:0]          r_t;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_last;

    // record state
    logic [TIME_BITS-1:0]          r_first_time, r_prev_time;
    logic signed [SAMPLE_BITS-1:0] r_prev_x, r_min, r_max;
    logic [2*SAMPLE_BITS-1:0]      r_prev_sq;
    logic [ACC_BITS-1:0]           r_sum, r_sq_acc;
    logic [1:0]                    r_count;
    logic                          r_sat;

    // per-sample pipeline
    logic [TIME_BITS-1:0]          r_dt;
    logic signed [SAMPLE_BITS:0]   r_pair;
    logic [2*SAMPLE_BITS-1:0]      r_x_sq;
    logic [ACC_BITS-1:0]           r_term, r_prod;

    // divider and root
    logic [ACC_BITS-1:0]           r_div_q, r_mean_q;
    logic [TIME_BITS:0]            r_div_rem;
    logic                          r_neg;
    logic [ACC_BITS-1:0]           r_rt_n, r_rt_root, r_rt_bit;

    logic                          r_out_valid;
    t_out_req                      r_out;

    logic signed [2*SAMPLE_BITS-1:0]             w_x_sq;
    logic signed [SAMPLE_BITS+TIME_BITS+1:0]     w_term;
    logic [2*SAMPLE_BITS-1:0]                    w_q;
    logic [ACC_BITS-1:0]                         w_prod;
    logic [ACC_BITS-1:0]                         w_sum_new;
    logic                                        w_sum_ovf;
    logic [ACC_BITS:0]                           w_sq_new;
    logic [TIME_BITS-1:0]                        w_dur;
    logic [TIME_BITS:0]                          w_den;
    logic [TIME_BITS+1:0]                        w_rem_sh, w_rem_sub;
    logic                                        w_ge;
    logic [ACC_BITS-1:0]                         w_trial;
    t_status                                     w_status;
    logic signed [SAMPLE_BITS-1:0]               w_mean;
    logic [SAMPLE_BITS-1:0]                      w_rms;
    logic [SAMPLE_BITS:0]                        w_span;

    assign w_x_sq    = r_x * r_x;
    assign w_term    = r_pair * $signed({1'b0, r_dt});
    assign w_q       = r_prev_sq + r_x_sq;
    assign w_prod    = w_q * r_dt;
    assign w_sum_new = r_sum + r_term;
    assign w_sum_ovf = (r_sum[ACC_BITS-1] == r_term[ACC_BITS-1])
                    && (w_sum_new[ACC_BITS-1] != r_sum[ACC_BITS-1]);
    assign w_sq_new  = {1'b0, r_sq_acc} + {1'b0, r_prod};

    assign w_dur     = r_t - r_first_time;
    assign w_den     = {w_dur, 1'b0};
    assign w_rem_sh  = {r_div_rem, r_div_q[ACC_BITS-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, w_den};
    assign w_ge      = (w_rem_sh >= {1'b0, w_den});
    assign w_trial   = r_rt_root + r_rt_bit;

    always_comb begin
        if (r_count != 2'd2) begin
            w_status = ST_SHORT;
        end else if (w_dur == '0) begin
            w_status = ST_ZERO_DUR;
        end else if (r_sat) begin
            w_status = ST_SATURATED;
        end else begin
            w_status = ST_OK;
        end

        if (r_neg) begin
            if (r_mean_q > 64'd32768) begin
                w_mean = SAMPLE_MIN;
            end else begin
                w_mean = -$signed(r_mean_q[SAMPLE_BITS-1:0]);
            end
        end else begin
            if (r_mean_q > 64'd32767) begin
                w_mean = SAMPLE_MAX;
            end else begin
                w_mean = $signed(r_mean_q[SAMPLE_BITS-1:0]);
            end
        end

        if (r_rt_root > 64'd32768) begin
            w_rms = 16'h8000;
        end else begin
            w_rms = r_rt_root[SAMPLE_BITS-1:0];
        end

        w_span = {r_max[SAMPLE_BITS-1], r_max} - {r_min[SAMPLE_BITS-1], r_min};
    end

    // record state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_time <= '0;
            r_prev_time  <= '0;
            r_prev_x     <= '0;
            r_prev_sq    <= '0;
            r_min        <= SAMPLE_MAX;
            r_max        <= SAMPLE_MIN;
            r_sum        <= '0;
            r_sq_acc     <= '0;
            r_count      <= '0;
            r_sat        <= 1'b0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_last <= i_in_req.last;
            end
            if (i_cmd.acc) begin
                if (r_count == 2'd0) begin
                    r_first_time <= r_t;
                end else begin
                    if (w_sum_ovf) begin
                        r_sat <= 1'b1;
                        r_sum <= r_sum[ACC_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                                   : {1'b0, {(ACC_BITS-1){1'b1}}};
                    end else begin
                        r_sum <= w_sum_new;
                    end
                    if (w_sq_new[ACC_BITS]) begin
                        r_sat    <= 1'b1;
                        r_sq_acc <= '1;
                    end else begin
                        r_sq_acc <= w_sq_new[ACC_BITS-1:0];
                    end
                end
                if (r_count != 2'd2) begin
                    r_count <= r_count + 2'd1;
                end
                r_prev_time <= r_t;
                r_prev_x    <= r_x;
                r_prev_sq   <= r_x_sq;
                if (r_x < r_min) begin
                    r_min <= r_x;
                end
                if (r_x > r_max) begin
                    r_max <= r_x;
                end
            end

            if (i_cmd.load) begin
                r_out_valid  <= 1'b1;
                // record done: back to reset values
                r_first_time <= '0;
                r_prev_time  <= '0;
                r_prev_x     <= '0;
                r_prev_sq    <= '0;
                r_min        <= SAMPLE_MAX;
                r_max        <= SAMPLE_MIN;
                r_sum        <= '0;
                r_sq_acc     <= '0;
                r_count      <= '0;
                r_sat        <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_t <= i_in_req.timestamp;
            r_x <= i_in_req.sample;
        end
        if (i_cmd.prep) begin
            r_dt   <= r_t - r_prev_time;
            r_pair <= {r_prev_x[SAMPLE_BITS-1], r_prev_x} + {r_x[SAMPLE_BITS-1], r_x};
            r_x_sq <= $unsigned(w_x_sq);
        end
        if (i_cmd.mul) begin
            r_term <= {{(ACC_BITS-SAMPLE_BITS-TIME_BITS-2){w_term[SAMPLE_BITS+TIME_BITS+1]}},
                       w_term};
            r_prod <= w_prod;
        end
        if (i_cmd.div_init_mean) begin
            r_neg     <= r_sum[ACC_BITS-1];
            r_div_q   <= r_sum[ACC_BITS-1] ? (~r_sum + 64'd1) : r_sum;
            r_div_rem <= '0;
        end
        if (i_cmd.div_init_sq) begin
            r_mean_q  <= r_div_q;
            r_div_q   <= r_sq_acc;
            r_div_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_q   <= {r_div_q[ACC_BITS-2:0], w_ge};
            r_div_rem <= w_ge ? w_rem_sub[TIME_BITS:0] : w_rem_sh[TIME_BITS:0];
        end
        if (i_cmd.root_init) begin
            r_rt_n    <= r_div_q;
            r_rt_root <= '0;
            r_rt_bit  <= {2'b01, {(ACC_BITS-2){1'b0}}};
        end
        if (i_cmd.root_step) begin
            if (r_rt_n >= w_trial) begin
                r_rt_n    <= r_rt_n - w_trial;
                r_rt_root <= (r_rt_root >> 1) + r_rt_bit;
            end else begin
                r_rt_root <= r_rt_root >> 1;
            end
            r_rt_bit <= r_rt_bit >> 2;
        end
        if (i_cmd.load) begin
            r_out.status     <= w_status;
            r_out.minimum    <= r_min;
            r_out.maximum    <= r_max;
            r_out.amplitude  <= w_span[SAMPLE_BITS-1:1];
            r_out.mean_value <= (w_status == ST_OK) ? w_mean : '0;
            r_out.rms_value  <= (w_status == ST_OK) ? w_rms : '0;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_req      = r_out;

endmodule

`default_nettype wire

[hw/rtl/trapezoid_signal_statistics.sv]
// ----------------------------------------------------------------------------
// trapezoid_signal_statistics: trapezoidal mean and rms meter
// Each sample request passes capture, difference, multiply and add; input stalls meanwhile.
// The last request then runs two 64-step divides and a 32-step root, with setup and load;
// load waits for a free output register. Reset: synchronous, active low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "trapezoid_signal_statistics_assert.svh"

module trapezoid_signal_statistics
    import tss_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    // sample requests
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_req,
    // result requests
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_req     o_out_req
);

    // The controller walks one sample at a time through the datapath:
    // it takes the difference to the previous timestamp, forms the doubled
    // trapezoid terms in the multiply state, then folds them into the
    // saturating accumulators. On the last sample it runs the serial
    // restoring divider twice (sum, then square sum, both over twice the
    // duration) and the bitwise square root on the second quotient.
    // The result register sits apart from the sequencer, so a pending
    // result does not block the next record from being collected.

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tss_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

    // an accepted sample always occupies the sequencer for the next cycle
    `TSS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // never overwrite a result that is still waiting
    `TSS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.load, !(o_out_valid && i_out_stall))

    // bad status zeroes mean and rms
    `TSS_ASSERT_NOW(a_status_zeroes, i_clk, i_rst_n,
        o_out_valid && (o_out_req.status != ST_OK),
        (o_out_req.mean_value == '0) && (o_out_req.rms_value == '0))

    // rms saturates at half the sample range
    `TSS_ASSERT_NOW(a_rms_range, i_clk, i_rst_n, o_out_valid, o_out_req.rms_value <= 16'h8000)

endmodule

`default_nettype wire
